// ===== design/lhc_pkg.sv =====
package lhc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int SLOT_W       = 4;
  localparam int LIMIT_W      = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lhc_state_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic in_stall;
    logic clr;
    logic rd_en;
    logic finish;
  } lhc_ctrl_t;

endpackage

// ===== design/lhc_key_ram.sv =====
module lhc_key_ram
  import lhc_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lhc_scan_unit.sv =====
module lhc_scan_unit
  import lhc_pkg::*;
#(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr,
  input  logic                   rd_en,
  input  logic [IDX_W-1:0]       rd_idx,
  input  logic [KEY_W-1:0]       key,
  input  logic [KEY_W-1:0]       key_q,
  input  logic                   valid_q,
  input  logic [IDX_W-1:0]       rank_q,
  output logic                   hit_found,
  output logic [IDX_W-1:0]       hit_idx,
  output logic [IDX_W-1:0]       hit_rank,
  output logic                   free_found,
  output logic [IDX_W-1:0]       free_idx,
  output logic                   lru_found,
  output logic [IDX_W-1:0]       lru_idx,
  output logic [KEY_W-1:0]       lru_key
);

  logic             cmp_en_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_found_r, free_found_r, lru_found_r;
  logic [IDX_W-1:0] hit_idx_r, hit_rank_r, free_idx_r, lru_idx_r, lru_rank_r;
  logic [KEY_W-1:0] lru_key_r;
  logic             take_hit, take_free, take_lru;

  // One entry per cycle: key match, first free slot, oldest valid entry
  assign take_hit  = cmp_en_r && valid_q && (key_q == key) && !hit_found_r;
  assign take_free = cmp_en_r && !valid_q && !free_found_r;
  assign take_lru  = cmp_en_r && valid_q && (!lru_found_r || (rank_q > lru_rank_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      lru_found_r  <= 1'b0;
    end else begin
      cmp_en_r <= rd_en;
      if (clr) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
        lru_found_r  <= 1'b0;
      end else begin
        if (take_hit)  hit_found_r  <= 1'b1;
        if (take_free) free_found_r <= 1'b1;
        if (take_lru)  lru_found_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx;
    if (take_hit) begin
      hit_idx_r  <= cmp_idx_r;
      hit_rank_r <= rank_q;
    end
    if (take_free) begin
      free_idx_r <= cmp_idx_r;
    end
    if (take_lru) begin
      lru_idx_r  <= cmp_idx_r;
      lru_rank_r <= rank_q;
      lru_key_r  <= key_q;
    end
  end

  assign hit_found  = hit_found_r;
  assign hit_idx    = hit_idx_r;
  assign hit_rank   = hit_rank_r;
  assign free_found = free_found_r;
  assign free_idx   = free_idx_r;
  assign lru_found  = lru_found_r;
  assign lru_idx    = lru_idx_r;
  assign lru_key    = lru_key_r;

endmodule

// ===== design/lhc_ctrl.sv =====
module lhc_ctrl
  import lhc_pkg::*;
#(
  parameter  int CAPACITY = CAPACITY_DEF,
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_free,
  output lhc_ctrl_t        ctl,
  output logic [IDX_W-1:0] rd_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  lhc_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    case (state_r)
      ST_IDLE: begin
        rd_idx_nxt = '0;
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.in_stall = 1'b0;
        ctl.clr      = in_valid;
      end
      ST_SCAN: begin
        ctl.in_stall = 1'b1;
        ctl.rd_en    = 1'b1;
      end
      ST_DRAIN: ctl.in_stall = 1'b1;
      ST_FINISH: begin
        ctl.in_stall = 1'b1;
        ctl.finish   = out_free;
      end
      default: ctl.in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  assign rd_idx = rd_idx_r;

endmodule

// ===== design/lru_handle_cache_core.sv =====
// Channel  | Ports                                        | Moves
// ---------+----------------------------------------------+---------------------------
// in       | in_valid, in_stall, in_lookup_key            | lookup request (one key)
// out      | out_valid, out_stall, out_hit, out_slot,     | lookup result
//          | out_evicted, out_evicted_key                 |
// cfg      | cfg_wr_en, cfg_wr_data                       | entry limit write
//
// A request is taken in the idle state. The sequencer then sweeps the
// single-read-port key store one slot per cycle, waits in a drain step for the
// last read and applies the update step; it goes back to idle before it takes
// the next request, and in_stall stays high in between.
// Reset (rst_n low, synchronous) empties the cache and sets the limit to 16.
// A finished result sits in the output register; a stalled result holds the
// sequencer in its update step, so nothing is lost while the sink stalls.
module lru_handle_cache_core
  import lhc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KEY_W-1:0]   in_lookup_key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_evicted,
  output logic [KEY_W-1:0]   out_evicted_key,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  lhc_ctrl_t        ctl;
  logic [IDX_W-1:0] rd_idx;
  logic             out_free;

  // Configuration
  logic [LIMIT_W-1:0] limit_r;

  // Cache state: ranks and valid bits in flops, keys in memory
  logic             valid_r   [CAPACITY];
  logic             valid_nxt [CAPACITY];
  logic [IDX_W-1:0] rank_r    [CAPACITY];
  logic [IDX_W-1:0] rank_nxt  [CAPACITY];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [KEY_W-1:0] key_r;
  logic [CAPACITY-1:0] valid_vec;

  // Per-entry state read in step with the key memory
  logic             valid_q_r;
  logic [IDX_W-1:0] rank_q_r;
  logic [KEY_W-1:0] key_q;

  // Scan results
  logic             hit_found, free_found, lru_found;
  logic [IDX_W-1:0] hit_idx, hit_rank, free_idx, lru_idx;
  logic [KEY_W-1:0] lru_key;

  // Update decision
  logic             fin_hit, fin_ev, fin_wr, fin_set_valid, fin_promote, fin_all, fin_inc;
  logic [IDX_W-1:0] fin_slot, fin_bound;
  logic [KEY_W-1:0] fin_ev_key;
  logic [LW-1:0]    lim_ext, eff_lim;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  // Output register
  logic              out_valid_r;
  logic              out_hit_r, out_evicted_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [KEY_W-1:0]  out_evicted_key_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = ctl.in_stall;

  lhc_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctl      (ctl),
    .rd_idx   (rd_idx)
  );

  // Read a key only from a slot that holds one
  lhc_key_ram #(.DEPTH(CAPACITY), .AW(IDX_W)) u_key_ram (
    .clk   (clk),
    .we    (fin_wr),
    .waddr (fin_slot),
    .wdata (key_r),
    .re    (ctl.rd_en && valid_r[rd_idx]),
    .raddr (rd_idx),
    .rdata (key_q)
  );

  lhc_scan_unit #(.CAPACITY(CAPACITY)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (ctl.clr),
    .rd_en      (ctl.rd_en),
    .rd_idx     (rd_idx),
    .key        (key_r),
    .key_q      (key_q),
    .valid_q    (valid_q_r),
    .rank_q     (rank_q_r),
    .hit_found  (hit_found),
    .hit_idx    (hit_idx),
    .hit_rank   (hit_rank),
    .free_found (free_found),
    .free_idx   (free_idx),
    .lru_found  (lru_found),
    .lru_idx    (lru_idx),
    .lru_key    (lru_key)
  );

  // Capture the key on accept; read slot state alongside the key memory
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      key_r <= in_lookup_key;
    end
    if (ctl.rd_en) begin
      valid_q_r <= valid_r[rd_idx];
      rank_q_r  <= rank_r[rd_idx];
    end
  end

  // Clamp the limit into 1..CAPACITY
  always_comb begin
    lim_ext = LW'(limit_r);
    if (lim_ext == '0) begin
      eff_lim = LW'(1);
    end else if (lim_ext > LW'(CAPACITY)) begin
      eff_lim = LW'(CAPACITY);
    end else begin
      eff_lim = lim_ext;
    end
  end

  // Decide hit, fill or evict from the finished scan
  always_comb begin
    fin_hit       = 1'b0;
    fin_ev        = 1'b0;
    fin_wr        = 1'b0;
    fin_set_valid = 1'b0;
    fin_promote   = 1'b0;
    fin_all       = 1'b0;
    fin_inc       = 1'b0;
    fin_slot      = '0;
    fin_bound     = '0;
    fin_ev_key    = '0;
    if (hit_found) begin
      // Hit: move to front, entries newer than it age by one
      fin_hit     = 1'b1;
      fin_slot    = hit_idx;
      fin_bound   = hit_rank;
      fin_promote = 1'b1;
    end else if (LW'(count_r) < eff_lim) begin
      // Fill the lowest free slot
      if (free_found) begin
        fin_slot      = free_idx;
        fin_promote   = 1'b1;
        fin_all       = 1'b1;
        fin_set_valid = 1'b1;
        fin_inc       = 1'b1;
        fin_wr        = 1'b1;
      end
    end else begin
      // Evict the oldest entry and reuse its slot
      fin_ev        = 1'b1;
      fin_promote   = 1'b1;
      fin_all       = 1'b1;
      fin_set_valid = 1'b1;
      fin_wr        = 1'b1;
      if (lru_found) begin
        fin_slot   = lru_idx;
        fin_ev_key = lru_key;
      end
    end
    if (!ctl.finish) begin
      fin_wr = 1'b0;
    end
  end

  // Next cache state; applied only on the update step
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
    end
    if (ctl.finish) begin
      if (fin_inc) begin
        count_nxt = count_r + 1'b1;
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (IDX_W'(i) == fin_slot) begin
          if (fin_set_valid) valid_nxt[i] = 1'b1;
          if (fin_promote)   rank_nxt[i]  = '0;
        end else if (fin_promote && valid_r[i] && (fin_all || (rank_r[i] < fin_bound))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
    end
  end

  // Result register: load on update, drop when the sink takes it
  assign slot_ext = {{SLOT_W{1'b0}}, fin_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_hit_r         <= fin_hit;
      out_slot_r        <= slot_ext[SLOT_W-1:0];
      out_evicted_r     <= fin_ev;
      out_evicted_key_r <= fin_ev_key;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  // Flatten the valid bits for the fill count check
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = valid_r[i];
    end
  end

  // Fill count tracks the number of valid slots
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("fill count out of step with valid bits");

  // The fill count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= CAPACITY)
    else $error("fill count above capacity");

  // An update step always presents a result next cycle
  a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> out_valid_r)
    else $error("update step without a result");

  // No new request is taken while the scan is running
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_en |-> in_stall)
    else $error("request accepted during scan");

endmodule

// ===== tb/lru_handle_cache_core_test.sv =====
`timescale 1ns / 1ps

module lru_handle_cache_core_test;
  import lhc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  // One request sweeps every slot plus read latency and update; allow slack.
  localparam int DRAIN_CYCLES = CAPACITY_DEF + 8;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 3;
  localparam int SEGMENTS     = 5;
  localparam int SEG_ITEMS    = 110;
  localparam int POOL_DEPTH   = 32;
  localparam int N_ROWS       = 22;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } lookup_result_t;

  typedef enum bit {ROW_LOOKUP, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    bit [KEY_W-1:0]     key;
    bit [LIMIT_W-1:0]   limit;
    bit                 typed;
    lookup_result_t     want;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup: every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [KEY_W-1:0]   in_lookup_key   = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic               out_hit;
  logic [SLOT_W-1:0]  out_slot;
  logic               out_evicted;
  logic [KEY_W-1:0]   out_evicted_key;
  logic               cfg_wr_en       = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data     = '0;

  lru_handle_cache_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_lookup_key   (in_lookup_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache: keys, valid bits, recency ages (0 = newest),
  // entry count and the raw limit register as last written.
  // ---------------------------------------------------------------------------
  bit [KEY_W-1:0]   line_key   [CAPACITY_DEF];
  bit               line_valid [CAPACITY_DEF];
  int unsigned      line_age   [CAPACITY_DEF];
  int unsigned      line_count = 0;
  bit [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;

  lookup_result_t awaited_results [$];
  lookup_result_t head_result;

  bit [KEY_W-1:0] key_pool [POOL_DEPTH];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_req_cnt  = 0;
  int hold_done_cnt = 0;
  int fail_count    = 0;
  int n_checked     = 0;
  int n_hits        = 0;
  int n_evicts      = 0;
  int n_limit_wr    = 0;
  int cycle_count   = 0;

  // Make slot s the newest: every valid line younger than bound ages by one.
  function automatic void make_newest(input int s, input int unsigned bound);
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      if (i != s && line_valid[i] && line_age[i] < bound) line_age[i]++;
    end
    line_age[s] = 0;
  endfunction

  // Apply one lookup to the shadow cache and return what the block must report.
  function automatic lookup_result_t predict_lookup(input bit [KEY_W-1:0] key);
    lookup_result_t r;
    int          found;
    int          pick;
    int unsigned eff_limit;
    int unsigned worst;
    bit          got;
    r     = '0;
    found = -1;
    pick  = 0;
    got   = 1'b0;
    worst = 0;
    // Clamp the limit: zero acts as one, anything above capacity as capacity.
    eff_limit = (limit_reg == 0) ? 1 :
                (limit_reg > CAPACITY_DEF) ? CAPACITY_DEF : limit_reg;

    for (int i = 0; i < CAPACITY_DEF; i++) begin
      if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
    end

    if (found >= 0) begin
      r.hit  = 1'b1;
      r.slot = found[SLOT_W-1:0];
      make_newest(found, line_age[found]);
    end else if (line_count < eff_limit) begin
      // Room left: take the lowest free slot.
      for (int i = CAPACITY_DEF - 1; i >= 0; i--) begin
        if (!line_valid[i]) pick = i;
      end
      r.slot = pick[SLOT_W-1:0];
      make_newest(pick, 32'hFFFF_FFFF);
      line_key[pick]   = key;
      line_valid[pick] = 1'b1;
      line_count++;
    end else begin
      // Full (or limit lowered below the count): evict the oldest, first on ties.
      for (int i = 0; i < CAPACITY_DEF; i++) begin
        if (line_valid[i] && (!got || line_age[i] > worst)) begin
          worst = line_age[i];
          pick  = i;
          got   = 1'b1;
        end
      end
      r.slot        = pick[SLOT_W-1:0];
      r.evicted     = 1'b1;
      r.evicted_key = line_key[pick];
      make_newest(pick, 32'hFFFF_FFFF);
      line_key[pick]   = key;
      line_valid[pick] = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Called at a rising edge; returns at the edge that took the
  // request. Gaps go in front of the request, never after it.
  // ---------------------------------------------------------------------------
  task automatic send_request(input bit [KEY_W-1:0] key, input bit typed,
                              input lookup_result_t want);
    lookup_result_t guess;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_lookup_key <= key;
    // Hold the payload until the block takes it.
    do @(posedge clk); while (in_stall);
    guess = predict_lookup(key);
    awaited_results.push_back(typed ? want : guess);
  endtask

  // Write the entry limit once the cache has gone quiet.
  task automatic write_limit(input bit [LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
    n_limit_wr++;
  endtask

  // Mostly reuse keys from a small pool so hits and evictions both happen.
  function automatic bit [KEY_W-1:0] pick_key(input int pool_size);
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(pool_size - 1)];
    return $urandom;
  endfunction

  task automatic report_field(input string name, input logic [KEY_W-1:0] want_v,
                              input logic [KEY_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed results are only given where they are obvious:
  // the first lookups after reset and those under the limit of one. The rest
  // come from the shadow cache.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_LOOKUP, 32'h0000_0000, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 32'h0000_0000}},
    '{ROW_LOOKUP, 32'hFFFF_FFFF, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b0, 32'h0000_0000}},
    '{ROW_LOOKUP, 32'h0000_0000, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 32'h0000_0000}},
    // limit zero acts as one, below the count of two
    '{ROW_LIMIT,  32'h0,         5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h0000_0005, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b1, 32'hFFFF_FFFF}},
    '{ROW_LOOKUP, 32'h0000_0000, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 32'h0000_0000}},
    '{ROW_LOOKUP, 32'h0000_0007, 5'd0,  1'b1, '{1'b0, 4'd1, 1'b1, 32'h0000_0005}},
    // top code clamps to capacity
    '{ROW_LIMIT,  32'h0,         5'd31, 1'b0, '0},
    '{ROW_LOOKUP, 32'hAAAA_AAAA, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h5555_5555, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h8000_0000, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h0000_0007, 5'd0,  1'b0, '0},
    // lower the limit under the count: misses evict, count stays put
    '{ROW_LIMIT,  32'h0,         5'd3,  1'b0, '0},
    '{ROW_LOOKUP, 32'h1234_5678, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'hAAAA_AAAA, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h0000_0001, 5'd0,  1'b0, '0},
    '{ROW_LIMIT,  32'h0,         5'd16, 1'b0, '0},
    '{ROW_LOOKUP, 32'hDEAD_BEEF, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h7FFF_FFFF, 5'd0,  1'b0, '0},
    '{ROW_LIMIT,  32'h0,         5'd1,  1'b0, '0},
    '{ROW_LOOKUP, 32'h0000_0000, 5'd0,  1'b0, '0},
    '{ROW_LOOKUP, 32'h0000_0000, 5'd0,  1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit [LIMIT_W-1:0] seg_limit;
    int               pool_size;
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      line_valid[i] = 1'b0;
      line_age[i]   = 0;
      line_key[i]   = '0;
    end

    // Hold reset for the first cycles, then release it once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct  = 18;
    sink_idle_pct = 70;
    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_LIMIT) write_limit(directed_rows[r].limit);
      else send_request(directed_rows[r].key, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random part: three idling phases, each split into limit segments.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 18;
          sink_idle_pct = 70;
        end
        1: begin
          src_idle_pct  = 70;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        // Start with the extremes, then mostly legal limits with some clamped codes.
        if (ph == 0 && seg == 0)      seg_limit = 5'd16;
        else if (ph == 0 && seg == 1) seg_limit = 5'd1;
        else if (ph == 0 && seg == 2) seg_limit = 5'd31;
        else if (ph == 0 && seg == 3) seg_limit = 5'd0;
        else if ($urandom_range(3) == 0) seg_limit = LIMIT_W'($urandom_range(31));
        else seg_limit = LIMIT_W'($urandom_range(CAPACITY_DEF, 1));
        write_limit(seg_limit);

        // Stall the sink for a long stretch while requests keep coming.
        if (seg == 2) hold_req_cnt++;

        for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
        key_pool[0] = (seg % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        pool_size   = $urandom_range(24, 2);

        for (int n = 0; n < SEG_ITEMS; n++) send_request(pick_key(pool_size), 1'b0, '0);
      end
    end

    // Drain and let the block settle.
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d lookups: %0d hits, %0d misses, %0d with eviction.",
             n_checked, n_hits, n_checked - n_hits, n_evicts);
    $display("Entry limit written %0d times incl. clamped codes; sink held off %0d times.",
             n_limit_wr, hold_done_cnt);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink: random stalls, plus a long hold-off whenever one is requested.
  // ---------------------------------------------------------------------------
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req_cnt != hold_done_cnt) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_done_cnt++;
      end else begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every taken result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual hit=%0b slot=%0d",
                 $time, out_hit, out_slot);
        fail_count++;
      end else begin
        head_result = awaited_results.pop_front();
        report_field("hit",         head_result.hit,         out_hit);
        report_field("slot",        head_result.slot,        out_slot);
        report_field("evicted",     head_result.evicted,     out_evicted);
        report_field("evicted_key", head_result.evicted_key, out_evicted_key);
        n_checked++;
        if (head_result.hit) n_hits++;
        if (head_result.evicted) n_evicts++;
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, awaited_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
